>>> rtl/ptrs_pkg.sv
`timescale 1ns / 1ps

package ptrs_pkg;

  localparam int MaxTasksDef = 8;
  localparam int MaxResults  = 8;
  localparam int PresclW     = 10;
  localparam int ResCntW     = $clog2(MaxResults + 1);

  localparam logic [7:0] TickDivRst = 8'd1;

  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_SCAN   = 2'd3;

  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_NONE     = 2'd2;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_NOT_FOUND = 2'd2;

  localparam logic [1:0] ST_INIT    = 2'd0;
  localparam logic [1:0] ST_WAITING = 2'd1;
  localparam logic [1:0] ST_READY   = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  task_id;
    logic [15:0] period;
    logic [7:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0] resp_kind;
    logic [7:0] task_id_out;
    logic [1:0] error;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] period;
    logic [7:0]  prio;
    logic [1:0]  status;
    logic [15:0] elapsed;
  } entry_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } push_t;

endpackage

>>> rtl/periodic_task_release_scheduler_unit.sv
`timescale 1ns / 1ps

// Periodic task release scheduler.
// Input channel in_valid_i / in_stall_o carries one request item: create,
// delete, tick or scan. Output channel out_valid_o / out_stall_i carries
// result items; the last result of a request has last set. Create and delete
// give one result, tick gives none, scan gives one per dispatched task or a
// single "nothing ready" result.
// The table sits in a single-port-read memory; a sequencer visits one entry
// at a time, in a check state and then an operate state. Create moves
// entries with a larger prio value up one slot to make room (none on a full
// table), delete searches for the task and shifts the later entries down,
// tick walks the table only on a prescaler release, and scan walks every
// entry. The final result turns valid in the cycle in which the next item
// can be taken. in_stall_o is high while an item is in work.
// The output register frees the sequencer to take the next item while the
// final result still waits. If out_stall_i is high, results hold in the
// output register and the scan walk holds until it can pass a result on.
// Reset clears the task count, prescaler and sequencer, sets tick_divider
// to 1 and drops any pending result. cfg_we_i writes tick_divider.
module periodic_task_release_scheduler_unit #(
  parameter int MAX_TASKS = ptrs_pkg::MaxTasksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptrs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptrs_pkg::out_item_t out_item_o
);

  localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CntW = $clog2(MAX_TASKS + 1);

  logic                out_valid_q;
  ptrs_pkg::out_item_t out_item_q;
  logic                out_rdy;
  ptrs_pkg::push_t     push;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  ptrs_pkg::entry_t    wr_data;
  logic [IdxW-1:0]     rd_addr;
  ptrs_pkg::entry_t    rd_data;

  assign out_rdy = !out_valid_q || !out_stall_i;

  ptrs_seq #(
    .MAX_TASKS (MAX_TASKS),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_rdy_i  (out_rdy),
    .push_o     (push),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  ptrs_table #(
    .MAX_TASKS (MAX_TASKS),
    .IdxW      (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_item_q <= push.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/ptrs_table.sv
`timescale 1ns / 1ps

module ptrs_table #(
  parameter int MAX_TASKS = ptrs_pkg::MaxTasksDef,
  parameter int IdxW      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  ptrs_pkg::entry_t  wr_data_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  output ptrs_pkg::entry_t  rd_data_o
);

  ptrs_pkg::entry_t mem [MAX_TASKS];
  ptrs_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/ptrs_seq.sv
`timescale 1ns / 1ps

module ptrs_seq #(
  parameter int MAX_TASKS = ptrs_pkg::MaxTasksDef,
  parameter int IdxW      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  parameter int CntW      = $clog2(MAX_TASKS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptrs_pkg::in_item_t in_item_i,
  input  logic               out_rdy_i,
  output ptrs_pkg::push_t    push_o,
  output logic               wr_en_o,
  output logic [IdxW-1:0]    wr_addr_o,
  output ptrs_pkg::entry_t   wr_data_o,
  output logic [IdxW-1:0]    rd_addr_o,
  input  ptrs_pkg::entry_t   rd_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_CR_CHK, S_CR_OP, S_DL_CHK, S_DL_OP,
    S_SH_CHK, S_SH_OP, S_WK_CHK, S_WK_OP, S_DONE
  } state_e;

  state_e                        state_q, state_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [CntW-1:0]               pos_q, pos_d;
  logic [ptrs_pkg::PresclW-1:0]  presc_q, presc_d;
  logic [7:0]                    div_q;
  logic [ptrs_pkg::ResCntW-1:0]  n_q, n_d;
  logic                          pend_vld_q, pend_vld_d;
  logic [7:0]                    pend_id_q, pend_id_d;
  ptrs_pkg::in_item_t            req_q, req_d;
  ptrs_pkg::out_item_t           fin_q, fin_d;

  logic [7:0]                    div_eff;
  logic [ptrs_pkg::PresclW:0]    presc_inc;
  logic [ptrs_pkg::PresclW:0]    presc_lim;
  logic [CntW-1:0]               slot_m1;
  logic [CntW:0]                 pos_p1;
  ptrs_pkg::entry_t              new_ent;
  ptrs_pkg::entry_t              upd_ent;

  assign div_eff   = (div_q == 8'd0) ? 8'd1 : div_q;
  assign presc_inc = {1'b0, presc_q} + (ptrs_pkg::PresclW + 1)'(1);
  assign presc_lim = (ptrs_pkg::PresclW + 1)'({div_eff, 2'b00});
  assign slot_m1   = pos_q - CntW'(1);
  assign pos_p1    = {1'b0, pos_q} + (CntW + 1)'(1);

  always_comb begin
    new_ent.id      = req_q.task_id;
    new_ent.period  = req_q.period;
    new_ent.prio    = req_q.priority_req;
    new_ent.status  = ptrs_pkg::ST_INIT;
    new_ent.elapsed = 16'd0;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    presc_d    = presc_q;
    n_d        = n_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    req_d      = req_q;
    fin_d      = fin_q;
    upd_ent    = rd_data_i;
    push_o     = '0;
    wr_en_o    = 1'b0;
    wr_addr_o  = pos_q[IdxW-1:0];
    wr_data_o  = rd_data_i;
    rd_addr_o  = pos_q[IdxW-1:0];
    in_stall_o = (state_q != S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_item_i;
          fin_d.resp_kind   = ptrs_pkg::KIND_STATUS;
          fin_d.task_id_out = in_item_i.task_id;
          fin_d.error       = ptrs_pkg::ERR_OK;
          fin_d.last        = 1'b1;
          pos_d      = '0;
          n_d        = '0;
          pend_vld_d = 1'b0;
          case (in_item_i.req_type)
            ptrs_pkg::REQ_CREATE: begin
              if ({1'b0, cnt_q} >= (CntW + 1)'(MAX_TASKS)) begin
                fin_d.error = ptrs_pkg::ERR_FULL;
                state_d     = S_DONE;
              end else begin
                pos_d   = cnt_q;
                state_d = S_CR_CHK;
              end
            end
            ptrs_pkg::REQ_DELETE: state_d = S_DL_CHK;
            ptrs_pkg::REQ_TICK: begin
              if (presc_inc >= presc_lim) begin
                presc_d = '0;
                state_d = S_WK_CHK;
              end else begin
                presc_d = presc_inc[ptrs_pkg::PresclW-1:0];
              end
            end
            default: state_d = S_WK_CHK;
          endcase
        end
      end

      S_CR_CHK: begin
        rd_addr_o = slot_m1[IdxW-1:0];
        if (pos_q == '0) begin
          wr_en_o   = 1'b1;
          wr_addr_o = pos_q[IdxW-1:0];
          wr_data_o = new_ent;
          cnt_d     = cnt_q + CntW'(1);
          state_d   = S_DONE;
        end else begin
          state_d = S_CR_OP;
        end
      end

      S_CR_OP: begin
        rd_addr_o = slot_m1[IdxW-1:0];
        wr_en_o   = 1'b1;
        wr_addr_o = pos_q[IdxW-1:0];
        if (rd_data_i.prio > req_q.priority_req) begin
          wr_data_o = rd_data_i;
          pos_d     = slot_m1;
          state_d   = S_CR_CHK;
        end else begin
          wr_data_o = new_ent;
          cnt_d     = cnt_q + CntW'(1);
          state_d   = S_DONE;
        end
      end

      S_DL_CHK: begin
        if (pos_q == cnt_q) begin
          fin_d.error = ptrs_pkg::ERR_NOT_FOUND;
          state_d     = S_DONE;
        end else begin
          state_d = S_DL_OP;
        end
      end

      S_DL_OP: begin
        if (rd_data_i.id == req_q.task_id) begin
          state_d = S_SH_CHK;
        end else begin
          pos_d   = pos_q + CntW'(1);
          state_d = S_DL_CHK;
        end
      end

      S_SH_CHK: begin
        rd_addr_o = pos_p1[IdxW-1:0];
        if (pos_p1 >= {1'b0, cnt_q}) begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_DONE;
        end else begin
          state_d = S_SH_OP;
        end
      end

      S_SH_OP: begin
        rd_addr_o = pos_p1[IdxW-1:0];
        wr_en_o   = 1'b1;
        wr_data_o = rd_data_i;
        pos_d     = pos_p1[CntW-1:0];
        state_d   = S_SH_CHK;
      end

      S_WK_CHK: begin
        if (pos_q == cnt_q) begin
          if (req_q.req_type == ptrs_pkg::REQ_SCAN) begin
            fin_d.last = 1'b1;
            fin_d.error = ptrs_pkg::ERR_OK;
            if (pend_vld_q) begin
              fin_d.resp_kind   = ptrs_pkg::KIND_DISPATCH;
              fin_d.task_id_out = pend_id_q;
            end else begin
              fin_d.resp_kind   = ptrs_pkg::KIND_NONE;
              fin_d.task_id_out = 8'd0;
            end
            state_d = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_WK_OP;
        end
      end

      S_WK_OP: begin
        pos_d   = pos_q + CntW'(1);
        state_d = S_WK_CHK;
        if (req_q.req_type == ptrs_pkg::REQ_TICK) begin
          upd_ent.elapsed = rd_data_i.elapsed + 16'd1;
          wr_en_o         = 1'b1;
          wr_data_o       = upd_ent;
        end else if (rd_data_i.status == ptrs_pkg::ST_READY) begin
          if (n_q < ptrs_pkg::ResCntW'(ptrs_pkg::MaxResults)) begin
            if (pend_vld_q && !out_rdy_i) begin
              pos_d   = pos_q;
              state_d = S_WK_OP;
            end else begin
              push_o.valid            = pend_vld_q;
              push_o.item.resp_kind   = ptrs_pkg::KIND_DISPATCH;
              push_o.item.task_id_out = pend_id_q;
              push_o.item.error       = ptrs_pkg::ERR_OK;
              push_o.item.last        = 1'b0;
              pend_vld_d              = 1'b1;
              pend_id_d               = rd_data_i.id;
              n_d                     = n_q + ptrs_pkg::ResCntW'(1);
              upd_ent.elapsed         = 16'd0;
              upd_ent.status          = ptrs_pkg::ST_WAITING;
              wr_en_o                 = 1'b1;
              wr_data_o               = upd_ent;
            end
          end
        end else if (rd_data_i.elapsed == rd_data_i.period) begin
          upd_ent.status = ptrs_pkg::ST_READY;
          wr_en_o        = 1'b1;
          wr_data_o      = upd_ent;
        end
      end

      S_DONE: begin
        if (out_rdy_i) begin
          push_o.valid = 1'b1;
          push_o.item  = fin_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      pos_q      <= '0;
      presc_q    <= '0;
      div_q      <= ptrs_pkg::TickDivRst;
      n_q        <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pos_q      <= pos_d;
      presc_q    <= presc_d;
      n_q        <= n_d;
      pend_vld_q <= pend_vld_d;
      if (cfg_we_i) begin
        div_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    fin_q     <= fin_d;
    pend_id_q <= pend_id_d;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= (CntW + 1)'(MAX_TASKS))
    else $error("task count above table size");

  a_push_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> out_rdy_i)
    else $error("result pushed into a full output stage");

  a_idle_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !wr_en_o)
    else $error("table write while idle");

  a_res_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= ptrs_pkg::ResCntW'(ptrs_pkg::MaxResults))
    else $error("dispatch budget exceeded");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (CntW'(wr_addr_o) <= cnt_q))
    else $error("table write beyond active entries");

endmodule
